>>> hw/rtl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("check failed");

`define CHK_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("check failed");

`endif

>>> hw/rtl/lext_pkg.sv
package lext_pkg;

  localparam int TableEntries = 64;
  localparam int IdxW = $clog2(TableEntries);
  localparam int CntW = $clog2(TableEntries + 1);
  localparam logic [31:0] TimeMax = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_REGISTER   = 2'd0,
    CMD_UNREGISTER = 2'd1,
    CMD_RENEWED    = 2'd2,
    CMD_QUERY      = 2'd3
  } cmd_t;

  localparam logic CFG_LEASE = 1'b0;
  localparam logic CFG_RENEW = 1'b1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [62:0]        chunk_key;
    logic signed [63:0] new_lease;
    logic [31:0]        now_secs;
  } in_word_t;

  typedef struct packed {
    logic               found;
    logic               lease_valid;
    logic               renew_due;
    logic signed [63:0] stored_lease;
    logic               table_full;
  } out_word_t;

  // key, lease, expiry, renew
  typedef struct packed {
    logic [62:0] key;
    logic [63:0] lease;
    logic [31:0] expiry;
    logic [31:0] renew_at;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_OUT
  } state_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[32] ? TimeMax : s[31:0];
  endfunction

endpackage

>>> hw/rtl/lext_ram.sv
module lext_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/lease_expiry_table_top.sv
// Lease table: sequential scan of a 64-entry RAM, one entry read per cycle.
// Each input word is captured in IDLE, scanned in SCAN, applied in WRITE and
// returned in OUT; one word in flight at a time, set by the single RAM read
// port scan.
// Used bits sit in flip-flops and clear at reset; entry payload is not reset.
// Intervals reset to 60 and 30.
module lease_expiry_table_top
  import lext_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  state_t state, state_next;
  logic [15:0] lease_interval, renew_interval;
  in_word_t cur;
  logic [TableEntries-1:0] used;
  logic [CntW-1:0] scan_cnt;      // address issued
  logic [IdxW-1:0] rd_idx;        // index of data on rdata
  logic rd_live;
  logic hit;
  logic [IdxW-1:0] hit_idx;
  entry_t hit_ent, rdata, wdata;
  logic free_ok;
  logic [IdxW-1:0] free_idx;
  logic we;
  out_word_t res;

  lext_ram #(.Width(EntryW), .Depth(TableEntries)) u_ram (
    .clk(clk), .we(we), .waddr(hit ? hit_idx : free_idx), .wdata(wdata),
    .raddr(scan_cnt[IdxW-1:0]), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lease_interval <= 16'd60;
      renew_interval <= 16'd30;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LEASE) begin
        lease_interval <= cfg_data;
      end else begin
        renew_interval <= cfg_data;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_SCAN;
      ST_SCAN:  if (!rd_live && scan_cnt == CntW'(TableEntries)) state_next = ST_WRITE;
      ST_WRITE: state_next = ST_OUT;
      ST_OUT:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    out_data = res;
    we = 1'b0;
    wdata = hit_ent;
    if (state == ST_WRITE) begin
      case (cmd_t'(cur.cmd))
        CMD_REGISTER: begin
          we = hit || free_ok;
          wdata.key = cur.chunk_key;
          wdata.lease = cur.new_lease;
          wdata.expiry = sat_add(cur.now_secs, lease_interval);
          wdata.renew_at = sat_add(cur.now_secs, renew_interval);
        end
        CMD_RENEWED: begin
          we = hit;
          wdata.expiry = sat_add(cur.now_secs, lease_interval);
          wdata.renew_at = sat_add(cur.now_secs, renew_interval);
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used <= '0;
      scan_cnt <= '0;
      rd_live <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          scan_cnt <= '0;
          rd_live <= 1'b0;
          hit <= 1'b0;
          free_ok <= 1'b0;
          free_idx <= '0;
          cur <= in_data;
        end
        ST_SCAN: begin
          if (scan_cnt != CntW'(TableEntries)) begin
            scan_cnt <= scan_cnt + 1'b1;
            rd_idx <= scan_cnt[IdxW-1:0];
            rd_live <= 1'b1;
          end else begin
            rd_live <= 1'b0;
          end
          if (rd_live) begin
            if (used[rd_idx] && rdata.key == cur.chunk_key) begin
              hit <= 1'b1;
              hit_idx <= rd_idx;
              hit_ent <= rdata;
            end
            if (!used[rd_idx] && !free_ok) begin
              free_ok <= 1'b1;
              free_idx <= rd_idx;
            end
          end
        end
        ST_WRITE: begin
          res.found <= hit;
          res.lease_valid <= hit && (cur.now_secs <= hit_ent.expiry);
          res.renew_due <= !hit || (cur.now_secs >= hit_ent.renew_at);
          res.stored_lease <= hit ? hit_ent.lease : 64'sd0;
          res.table_full <= (cur.cmd == CMD_REGISTER) && !hit && !free_ok;
          if (cur.cmd == CMD_REGISTER && !hit && free_ok) begin
            used[free_idx] <= 1'b1;
          end
          if (cur.cmd == CMD_UNREGISTER && hit) begin
            used[hit_idx] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

>>> hw/rtl/lext_checker.sv
`include "assert_macros.svh"
module lext_checker
  import lext_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);
  `CHK_IMPLY(a_no_overlap, clk, rst, out_valid, !in_ready)
  `CHK_IMPLY(a_valid_needs_found, clk, rst, out_valid, !out_data.lease_valid || out_data.found)
  `CHK_IMPLY(a_full_not_found, clk, rst, out_valid, !out_data.table_full || !out_data.found)
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `CHK_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !out_valid && !in_ready)
endmodule

bind lease_expiry_table_top lext_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

>>> sim/lease_expiry_table_top_test.sv
module lease_expiry_table_top_test;
  import lext_pkg::*;

  localparam int SettleCycles = TableEntries + 8;
  localparam int StallLimit = 20 * (TableEntries + 3) + 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_LEASE;
  logic [15:0] cfg_data = '0;

  lease_expiry_table_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // lease table mirror
  logic [15:0] lease_ivl, renew_ivl;
  logic        slot_used [TableEntries];
  logic [62:0] slot_key [TableEntries];
  logic [63:0] slot_lease [TableEntries];
  logic [31:0] slot_expiry [TableEntries];
  logic [31:0] slot_renew [TableEntries];

  out_word_t pending_results[$];
  logic [62:0] known_keys[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int full_hits = 0;
  int idle_cnt = 0;
  bit calm = 1'b0;

  function automatic logic [31:0] time_plus(logic [31:0] t, logic [15:0] span);
    logic [32:0] s;
    s = {1'b0, t} + {17'd0, span};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic out_word_t table_apply(in_word_t w);
    out_word_t r;
    int hit, spot;
    hit = -1;
    spot = -1;
    for (int i = 0; i < TableEntries; i++)
      if (slot_used[i] && slot_key[i] == w.chunk_key && hit < 0) hit = i;
    r = '0;
    r.renew_due = 1'b1;
    if (hit >= 0) begin
      r.found = 1'b1;
      r.lease_valid = w.now_secs <= slot_expiry[hit];
      r.renew_due = w.now_secs >= slot_renew[hit];
      r.stored_lease = slot_lease[hit];
    end
    case (cmd_t'(w.cmd))
      CMD_REGISTER: begin
        spot = hit;
        if (spot < 0)
          for (int i = 0; i < TableEntries; i++)
            if (!slot_used[i] && spot < 0) spot = i;
        if (spot < 0) r.table_full = 1'b1;
        else begin
          slot_used[spot] = 1'b1;
          slot_key[spot] = w.chunk_key;
          slot_lease[spot] = w.new_lease;
          slot_expiry[spot] = time_plus(w.now_secs, lease_ivl);
          slot_renew[spot] = time_plus(w.now_secs, renew_ivl);
        end
      end
      CMD_UNREGISTER: if (hit >= 0) slot_used[hit] = 1'b0;
      CMD_RENEWED: if (hit >= 0) begin
        slot_expiry[hit] = time_plus(w.now_secs, lease_ivl);
        slot_renew[hit] = time_plus(w.now_secs, renew_ivl);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(logic [1:0] c, logic [62:0] k, logic [63:0] l,
                           logic [31:0] t);
    in_word_t w;
    w.cmd = c;
    w.chunk_key = k;
    w.new_lease = l;
    w.now_secs = t;
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 16)) @(negedge clk);
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(table_apply(w));
    if (c == CMD_REGISTER) known_keys.push_back(k);
    words_sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LEASE) lease_ivl = v;
    else renew_ivl = v;
  endtask

  function automatic logic [62:0] pick_key();
    if (known_keys.size() != 0 && $urandom_range(0, 3) != 0)
      return known_keys[$urandom_range(0, known_keys.size() - 1)];
    return 63'({$urandom, $urandom});
  endfunction

  // result checker and sink stalls
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_data);
        errors++;
      end else begin
        out_word_t e;
        e = pending_results.pop_front();
        words_checked++;
        if (out_data.found !== e.found || out_data.lease_valid !== e.lease_valid ||
            out_data.renew_due !== e.renew_due ||
            out_data.stored_lease !== e.stored_lease ||
            out_data.table_full !== e.table_full) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, out_data);
          errors++;
        end
        if (e.table_full) full_hits++;
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (calm) out_ready <= 1'b1;
      else if ($urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_ready <= 1'b1;
      end else out_ready <= 1'b1;
    end
  end

  // stall watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > StallLimit) begin
      $display("lease_expiry_table_top_test: FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    send_word(CMD_QUERY, 63'h0, 64'h0, 32'h0);
    send_word(CMD_UNREGISTER, 63'h5, 64'h0, 32'h10);
    send_word(CMD_RENEWED, 63'h5, 64'h0, 32'h10);
    send_word(CMD_REGISTER, 63'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 32'h0);
    send_word(CMD_QUERY, 63'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd30);
    send_word(CMD_QUERY, 63'h7FFF_FFFF_FFFF_FFFF, 64'h0, 32'd60);
    send_word(CMD_QUERY, 63'h7FFF_FFFF_FFFF_FFFF, 64'h0, 32'd61);
    send_word(CMD_REGISTER, 63'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 32'd100);
    send_word(CMD_RENEWED, 63'h7FFF_FFFF_FFFF_FFFF, 64'h0, 32'd200);
    send_word(CMD_QUERY, 63'h7FFF_FFFF_FFFF_FFFF, 64'h0, 32'd229);
    send_word(CMD_REGISTER, 63'h1, 64'h1, 32'hFFFF_FFF0);
    send_word(CMD_QUERY, 63'h1, 64'h0, 32'hFFFF_FFFF);
    send_word(CMD_UNREGISTER, 63'h1, 64'h0, 32'hFFFF_FFFF);
    send_word(CMD_QUERY, 63'h1, 64'h0, 32'hFFFF_FFFF);
    send_word(CMD_UNREGISTER, 63'h7FFF_FFFF_FFFF_FFFF, 64'h0, 32'd0);
  endtask

  task automatic test_config_extremes();
    write_cfg(CFG_LEASE, 16'hFFFF);
    write_cfg(CFG_RENEW, 16'h1);
    send_word(CMD_REGISTER, 63'h22, 64'h1234, 32'hFFFF_0100);
    send_word(CMD_QUERY, 63'h22, 64'h0, 32'hFFFF_0101);
    write_cfg(CFG_LEASE, 16'h0);
    write_cfg(CFG_RENEW, 16'h0);
    send_word(CMD_RENEWED, 63'h22, 64'h0, 32'd500);
    send_word(CMD_QUERY, 63'h22, 64'h0, 32'd500);
    send_word(CMD_QUERY, 63'h22, 64'h0, 32'd501);
    send_word(CMD_UNREGISTER, 63'h22, 64'h0, 32'd501);
  endtask

  task automatic test_table_full();
    write_cfg(CFG_LEASE, 16'd60);
    write_cfg(CFG_RENEW, 16'd30);
    for (int i = 0; i < TableEntries + 3; i++)
      send_word(CMD_REGISTER, 63'h100 + i, {$urandom, $urandom}, 32'd1000 + i);
    send_word(CMD_REGISTER, 63'h100, 64'hABCD, 32'd2000);
    send_word(CMD_UNREGISTER, 63'h105, 64'h0, 32'd2001);
    send_word(CMD_REGISTER, 63'h900, 64'h5, 32'd2002);
    send_word(CMD_QUERY, 63'h900, 64'h0, 32'd2003);
    for (int i = 0; i < TableEntries + 3; i++)
      send_word(CMD_UNREGISTER, 63'h100 + i, 64'h0, 32'd3000);
    send_word(CMD_UNREGISTER, 63'h900, 64'h0, 32'd3000);
  endtask

  task automatic test_random(int n);
    logic [31:0] clock_now;
    logic [31:0] t;
    clock_now = $urandom;
    known_keys.delete();
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) drain();
      if (i == n / 2) begin
        write_cfg(CFG_LEASE, 16'($urandom_range(1, 200)));
        write_cfg(CFG_RENEW, 16'($urandom_range(1, 200)));
      end
      if (i == 3 * n / 4) begin
        calm = 1'b1;
        write_cfg(CFG_LEASE, 16'($urandom));
      end
      clock_now = clock_now + $urandom_range(0, 40);
      t = ($urandom_range(0, 19) == 0) ? $urandom : clock_now;
      if (known_keys.size() > 200) known_keys.delete(0);
      send_word(2'($urandom_range(0, 3)), pick_key(), {$urandom, $urandom}, t);
    end
  endtask

  initial begin
    lease_ivl = 16'd60;
    renew_ivl = 16'd30;
    for (int i = 0; i < TableEntries; i++) slot_used[i] = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_extremes();
    test_table_full();
    test_random(840);
    drain();
    $display("Covered %0d words (%0d results checked), %0d table-full refusals,",
             words_sent, words_checked, full_hits);
    $display("interval extremes, saturation and random lease traffic with stalls.");
    if (errors == 0 && pending_results.size() == 0)
      $display("lease_expiry_table_top_test: PASS");
    else
      $display("lease_expiry_table_top_test: FAIL");
    $finish;
  end

endmodule
